// ----- rtl/core/k2r_pkg.sv -----
// k2r_pkg: shared types, constants and romaji tables for the kana-to-romaji block.
// No dependencies.
package k2r_pkg;

  localparam logic [15:0] HiraBase     = 16'h3040;
  localparam logic [15:0] KataBase     = 16'h30A0;
  localparam logic [15:0] KataSmallTsu = 16'h30C3;
  localparam logic [15:0] KataLongMark = 16'h30FC;
  localparam int unsigned TableSize    = 84;
  localparam int unsigned QDepth       = 2;

  // Up to three letters of one romaji string, packed char0 in [7:0].
  typedef struct packed {
    logic [1:0]  len;
    logic [23:0] chars;
  } romaji_t;

  // One job for the back end: up to six characters.
  typedef struct packed {
    logic [2:0]      cnt;
    logic [5:0][15:0] chars;
  } job_t;

  function automatic romaji_t str3(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    romaji_t r;
    r.len   = (a == 8'd0) ? 2'd0 : (b == 8'd0) ? 2'd1 : (c == 8'd0) ? 2'd2 : 2'd3;
    r.chars = {c, b, a};
    return r;
  endfunction

  function automatic romaji_t single_lut(input logic [6:0] off);
    romaji_t r;
    case (off)
      7'h02: r = str3("a", 0, 0);   7'h04: r = str3("i", 0, 0);
      7'h06: r = str3("u", 0, 0);   7'h08: r = str3("e", 0, 0);
      7'h0A: r = str3("o", 0, 0);
      7'h0B: r = str3("k", "a", 0); 7'h0C: r = str3("g", "a", 0);
      7'h0D: r = str3("k", "i", 0); 7'h0E: r = str3("g", "i", 0);
      7'h0F: r = str3("k", "u", 0); 7'h10: r = str3("g", "u", 0);
      7'h11: r = str3("k", "e", 0); 7'h12: r = str3("g", "e", 0);
      7'h13: r = str3("k", "o", 0); 7'h14: r = str3("g", "o", 0);
      7'h15: r = str3("s", "a", 0); 7'h16: r = str3("z", "a", 0);
      7'h17: r = str3("s", "h", "i"); 7'h18: r = str3("j", "i", 0);
      7'h19: r = str3("s", "u", 0); 7'h1A: r = str3("z", "u", 0);
      7'h1B: r = str3("s", "e", 0); 7'h1C: r = str3("z", "e", 0);
      7'h1D: r = str3("s", "o", 0); 7'h1E: r = str3("z", "o", 0);
      7'h1F: r = str3("t", "a", 0); 7'h20: r = str3("d", "a", 0);
      7'h21: r = str3("c", "h", "i"); 7'h22: r = str3("j", "i", 0);
      7'h24: r = str3("t", "s", "u"); 7'h25: r = str3("z", "u", 0);
      7'h26: r = str3("t", "e", 0); 7'h27: r = str3("d", "e", 0);
      7'h28: r = str3("t", "o", 0); 7'h29: r = str3("d", "o", 0);
      7'h2A: r = str3("n", "a", 0); 7'h2B: r = str3("n", "i", 0);
      7'h2C: r = str3("n", "u", 0); 7'h2D: r = str3("n", "e", 0);
      7'h2E: r = str3("n", "o", 0);
      7'h2F: r = str3("h", "a", 0); 7'h30: r = str3("b", "a", 0);
      7'h31: r = str3("p", "a", 0); 7'h32: r = str3("h", "i", 0);
      7'h33: r = str3("b", "i", 0); 7'h34: r = str3("p", "i", 0);
      7'h35: r = str3("f", "u", 0); 7'h36: r = str3("b", "u", 0);
      7'h37: r = str3("p", "u", 0); 7'h38: r = str3("h", "e", 0);
      7'h39: r = str3("b", "e", 0); 7'h3A: r = str3("p", "e", 0);
      7'h3B: r = str3("h", "o", 0); 7'h3C: r = str3("b", "o", 0);
      7'h3D: r = str3("p", "o", 0);
      7'h3E: r = str3("m", "a", 0); 7'h3F: r = str3("m", "i", 0);
      7'h40: r = str3("m", "u", 0); 7'h41: r = str3("m", "e", 0);
      7'h42: r = str3("m", "o", 0);
      7'h44: r = str3("y", "a", 0); 7'h46: r = str3("y", "u", 0);
      7'h48: r = str3("y", "o", 0);
      7'h49: r = str3("r", "a", 0); 7'h4A: r = str3("r", "i", 0);
      7'h4B: r = str3("r", "u", 0); 7'h4C: r = str3("r", "e", 0);
      7'h4D: r = str3("r", "o", 0);
      7'h4F: r = str3("w", "a", 0); 7'h52: r = str3("w", "o", 0);
      7'h53: r = str3("n", 0, 0);
      default: r = str3(0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic romaji_t yoon_lut(input logic [6:0] off);
    romaji_t r;
    case (off)
      7'h0D: r = str3("k", "y", 0); 7'h0E: r = str3("g", "y", 0);
      7'h17: r = str3("s", "h", 0); 7'h18: r = str3("j", 0, 0);
      7'h21: r = str3("c", "h", 0); 7'h2B: r = str3("n", "y", 0);
      7'h32: r = str3("h", "y", 0); 7'h33: r = str3("b", "y", 0);
      7'h34: r = str3("p", "y", 0); 7'h3F: r = str3("m", "y", 0);
      7'h4A: r = str3("r", "y", 0);
      default: r = str3(0, 0, 0);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/k2r_front.sv -----
// k2r_front: holds one code point, matches yoon pairs and singles, builds jobs.
// Depends on k2r_pkg.
module k2r_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            kana_mode_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [15:0]     code_point_i,
  input  logic            end_of_text_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output k2r_pkg::job_t   job_o
);

  logic [15:0] held_q, held_d;
  logic        hv_q, hv_d;
  logic [15:0] base;

  assign base = kana_mode_i ? k2r_pkg::KataBase : k2r_pkg::HiraBase;

  // Translation of one code point alone.
  function automatic k2r_pkg::job_t single(input logic [15:0] cp, input logic kata,
                                           input logic [15:0] b);
    k2r_pkg::job_t   j;
    k2r_pkg::romaji_t r;
    logic [15:0]     off;
    off = cp - b;
    r = k2r_pkg::single_lut(off[6:0]);
    j = '0;
    if (kata && cp == k2r_pkg::KataSmallTsu) begin
      j.cnt = 3'd0;
    end else if (kata && cp == k2r_pkg::KataLongMark) begin
      j.cnt = 3'd1;
      j.chars[0] = 16'h002D;
    end else if (cp >= b && off < 16'(k2r_pkg::TableSize) && r.len != 2'd0) begin
      j.cnt = {1'b0, r.len};
      j.chars[0] = {8'd0, r.chars[7:0]};
      j.chars[1] = {8'd0, r.chars[15:8]};
      j.chars[2] = {8'd0, r.chars[23:16]};
    end else begin
      j.cnt = 3'd1;
      j.chars[0] = cp;
    end
    return j;
  endfunction

  k2r_pkg::job_t    ja, jb, jn;
  k2r_pkg::romaji_t y;
  logic [15:0]      ao, so;
  logic             pair;
  logic [7:0]       vow;

  always_comb begin
    ao  = held_q - base;
    so  = code_point_i - base;
    y   = k2r_pkg::yoon_lut(ao[6:0]);
    vow = (so == 16'h43) ? "a" : (so == 16'h45) ? "u" : (so == 16'h47) ? "o" : 8'd0;
    pair = hv_q && held_q >= base && code_point_i >= base &&
           ao < 16'(k2r_pkg::TableSize) && y.len != 2'd0 && vow != 8'd0;
    ja = single(held_q, kana_mode_i, base);
    jb = single(code_point_i, kana_mode_i, base);
    jn = '0;
    held_d = held_q;
    hv_d   = hv_q;
    if (pair) begin
      jn.cnt = {1'b0, y.len} + 3'd1;
      jn.chars[0] = {8'd0, y.chars[7:0]};
      jn.chars[1] = (y.len == 2'd1) ? {8'd0, vow} : {8'd0, y.chars[15:8]};
      jn.chars[2] = {8'd0, vow};
      hv_d = 1'b0;
      held_d = '0;
    end else begin
      if (hv_q) jn = ja;
      if (end_of_text_i) begin
        // append the new code point's translation behind the held one
        for (int i = 0; i < 3; i++) begin
          if (3'(i) < jb.cnt) jn.chars[3'(i) + jn.cnt] = jb.chars[3'(i)];
        end
        jn.cnt = jn.cnt + jb.cnt;
        hv_d = 1'b0;
        held_d = '0;
      end else begin
        hv_d = 1'b1;
        held_d = code_point_i;
      end
    end
  end

  assign in_stall_o  = !job_ready_i;
  assign job_valid_o = in_valid_i && jn.cnt != 3'd0;
  assign job_o       = jn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      hv_q   <= 1'b0;
    end else if (in_valid_i && job_ready_i) begin
      held_q <= held_d;
      hv_q   <= hv_d;
    end
  end

endmodule

// ----- rtl/core/k2r_back.sv -----
// k2r_back: two-entry job queue and serializer, one character per cycle unless out_stall_i holds it.
// Depends on k2r_pkg.
module k2r_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  k2r_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [15:0]   out_char_o,
  output logic          last_of_run_o
);

  k2r_pkg::job_t q_q [k2r_pkg::QDepth];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic [2:0]    pos_q;
  logic          push, pop, fire;
  k2r_pkg::job_t head;

  assign head        = q_q[rp_q];
  assign job_ready_o = cnt_q != 2'(k2r_pkg::QDepth);
  assign push        = job_valid_i && job_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_char_o  = head.chars[pos_q];
  assign last_of_run_o = (pos_q + 3'd1) == head.cnt;
  assign fire        = out_valid_o && !out_stall_i;
  assign pop         = fire && last_of_run_o;

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) begin
        rp_q  <= !rp_q;
        pos_q <= '0;
      end else if (fire) begin
        pos_q <= pos_q + 3'd1;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(k2r_pkg::QDepth)) else $error("queue overflow");
  a_pos_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_q < head.cnt) else $error("position past job");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");
`endif

endmodule

// ----- rtl/core/kana_to_romaji_transliterator_top.sv -----
// kana_to_romaji_transliterator_top: kana to Hepburn romaji transliterator.
// Depends on k2r_pkg, k2r_front, k2r_back.
//
// Input channel: in_valid_i/in_stall_o with code_point_i and end_of_text_i.
// Output channel: out_valid_o/out_stall_i with out_char_o and last_of_run_o,
// one character per transaction; last_of_run_o marks the final character of
// each queued job. Config channel: cfg_valid_i/cfg_ready_o, cfg_data_i[0]
// sets kana mode (0 hiragana, 1 katakana); write only while idle.
// The front end holds one code point for yoon lookahead, so a character's
// output normally appears when the next input (or end_of_text) arrives.
// The back end drains one character per cycle while the receiver does not
// stall, from a two-entry job queue. Inputs that produce no output (held first
// character, katakana small tsu) push no job. A receiver stall backs up the
// queue; input stalls once both entries are full. Reset clears the held
// character, the queue and the mode register (hiragana).
module kana_to_romaji_transliterator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_point_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_char_o,
  output logic        last_of_run_o
);

  logic          mode_q;
  logic          job_valid, job_ready;
  k2r_pkg::job_t job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end

  k2r_front u_front (
    .clk_i, .rst_ni, .kana_mode_i(mode_q), .in_valid_i, .in_stall_o,
    .code_point_i, .end_of_text_i, .job_valid_o(job_valid),
    .job_ready_i(job_ready), .job_o(job)
  );

  k2r_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_valid_o, .out_stall_i, .out_char_o, .last_of_run_o
  );

endmodule
